### rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// shared types, widths and register codes of the sampson inlier counter
// ----------------------------------------------------------------------------
package sic_pkg;

    // set size and running count
    localparam int MAX_PAIRS = 4096;
    localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

    // field widths
    localparam int PT_W    = 16;
    localparam int COEF_W  = 21;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int LIMIT_W = 32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);

    // configuration register codes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_F_ROW_ONE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_F_ROW_TWO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_F_ROW_THREE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INLIER_LIMIT = 2'd3;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // datapath widths
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int L_MAG_W  = 37;   // |epipolar line component| <= 3 * 2^35
    localparam int S_MAG_W  = 54;   // |algebraic error| <= 9 * 2^50
    localparam int NUM_W    = 108;  // s^2
    localparam int DEN_W    = 76;   // sum of four squared line parts
    localparam int LIM_W    = 108;  // threshold * den
    localparam int ACC_W    = 109;  // signed accumulator
    localparam int THR_FRAC = 16;   // threshold is Q16.16
    localparam int CMP_W    = NUM_W + THR_FRAC;

    localparam logic [1:0] GAP_LAST = 2'd2;

    typedef struct packed {
        logic signed [PT_W-1:0] first_x;
        logic signed [PT_W-1:0] first_y;
        logic signed [PT_W-1:0] first_w;
        logic signed [PT_W-1:0] second_x;
        logic signed [PT_W-1:0] second_y;
        logic signed [PT_W-1:0] second_w;
        logic                   last_pair;
    } pair_t;

    typedef struct packed {
        logic             is_inlier;
        logic [CNT_W-1:0] inlier_total;
        logic             set_done;
    } result_t;

    // queued request in sign / magnitude form
    typedef struct packed {
        logic [2:0][PT_W-1:0] p1_mag;
        logic [2:0]           p1_neg;
        logic [2:0][PT_W-1:0] p2_mag;
        logic [2:0]           p2_neg;
        logic                 last;
    } entry_t;

    // verdict handed from back end to output stage
    typedef struct packed {
        logic is_inlier;
        logic last;
    } verdict_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_RUN,
        E_GAP,
        E_DECIDE
    } eng_state_t;

    typedef enum logic [2:0] {
        PH_L1,
        PH_L2,
        PH_S,
        PH_NUM,
        PH_DEN,
        PH_LIM
    } phase_t;

    // control word traveling with one multiply step
    typedef struct packed {
        logic       valid;
        logic       neg;
        logic [1:0] shift;
        logic       first;
        logic       last;
        phase_t     phase;
        logic [1:0] idx;
    } ctl_t;

endpackage

### rtl/sic_front.sv
// ----------------------------------------------------------------------------
// sic_front
// accepts point pairs, splits coordinates into sign and magnitude, queues them
// ----------------------------------------------------------------------------
module sic_front import sic_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    output logic   full,
    input  pair_t  item,
    output entry_t head,
    output logic   head_empty,
    input  logic   head_pop
);

    entry_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    entry_t              entry_in;
    logic                wr_en;
    logic                rd_en;

    function automatic logic [PT_W-1:0] pt_mag(input logic signed [PT_W-1:0] v);
        // wraps correctly for the most negative value
        pt_mag = v[PT_W-1] ? PT_W'(-v) : PT_W'(v);
    endfunction

    always_comb
    begin
        entry_in.p1_mag[0] = pt_mag(item.first_x);
        entry_in.p1_mag[1] = pt_mag(item.first_y);
        entry_in.p1_mag[2] = pt_mag(item.first_w);
        entry_in.p1_neg    = {item.first_w[PT_W-1], item.first_y[PT_W-1],
                              item.first_x[PT_W-1]};
        entry_in.p2_mag[0] = pt_mag(item.second_x);
        entry_in.p2_mag[1] = pt_mag(item.second_y);
        entry_in.p2_mag[2] = pt_mag(item.second_w);
        entry_in.p2_neg    = {item.second_w[PT_W-1], item.second_y[PT_W-1],
                              item.second_x[PT_W-1]};
        entry_in.last      = item.last_pair;
    end

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_empty = (count_reg == '0);
    assign wr_en      = push && !full;
    assign rd_en      = head_pop && !head_empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("request queue count beyond depth");
`endif

endmodule

### rtl/sic_engine.sv
// ----------------------------------------------------------------------------
// sic_engine
// scores one queued pair with a shared 32x32 multiplier and wide accumulator
// ----------------------------------------------------------------------------
module sic_engine import sic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  entry_t             head,
    input  logic               head_empty,
    output logic               head_pop,
    input  logic [ROW_W-1:0]   f_row_one,
    input  logic [ROW_W-1:0]   f_row_two,
    input  logic [ROW_W-1:0]   f_row_three,
    input  logic [LIMIT_W-1:0] inlier_limit,
    output verdict_t           verdict,
    output logic               res_valid,
    input  logic               res_ready
);

    eng_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] u_reg, u_next;
    logic [1:0] v_reg, v_next;
    logic [1:0] gap_reg, gap_next;
    logic [1:0] u_last, v_last;
    logic       issue;
    logic       decide_now;

    entry_t     item_reg;

    // operand selection
    logic [2:0][ROW_W-1:0] rows;
    logic [1:0]            coef_r, coef_c;
    logic [COEF_W-1:0]     coef;
    logic [COEF_W-1:0]     coef_mag;
    logic                  coef_neg;
    logic [L_MAG_W-1:0]    den_line;
    logic [MUL_W-1:0]      a_sel, b_sel;
    ctl_t                  ctl_sel;

    // multiply pipeline
    logic [MUL_W-1:0]  a_reg, b_reg;
    ctl_t              ctl1_reg, ctl2_reg, ctl3_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  addend, base;
    logic [ACC_W-1:0]  acc_abs;

    // intermediate results
    logic [L_MAG_W-1:0] l1_mag_reg [3];
    logic [2:0]         l1_neg_reg;
    logic [L_MAG_W-1:0] l2_mag_reg [2];
    logic [S_MAG_W-1:0] s_mag_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic               inl_reg;
    logic [CMP_W-1:0]   num_scaled, lim_ext;

    function automatic logic [MUL_W-1:0] l_chunk(input logic [L_MAG_W-1:0] m, input logic h);
        l_chunk = h ? MUL_W'(m[L_MAG_W-1:MUL_W]) : m[MUL_W-1:0];
    endfunction

    function automatic logic [MUL_W-1:0] s_chunk(input logic [S_MAG_W-1:0] m, input logic h);
        s_chunk = h ? MUL_W'(m[S_MAG_W-1:MUL_W]) : m[MUL_W-1:0];
    endfunction

    function automatic logic [MUL_W-1:0] d_chunk(input logic [DEN_W-1:0] m, input logic [1:0] h);
        logic [MUL_W-1:0] r;
        unique case (h)
            2'd0:    r = m[MUL_W-1:0];
            2'd1:    r = m[2*MUL_W-1:MUL_W];
            default: r = MUL_W'(m[DEN_W-1:2*MUL_W]);
        endcase
        return r;
    endfunction

    function automatic phase_t phase_after(input phase_t p);
        phase_t r;
        unique case (p)
            PH_L1:   r = PH_L2;
            PH_L2:   r = PH_S;
            PH_S:    r = PH_NUM;
            PH_NUM:  r = PH_DEN;
            PH_DEN:  r = PH_LIM;
            default: r = PH_LIM;
        endcase
        return r;
    endfunction

    // loop bounds of each phase: outer u, inner v
    always_comb
    begin
        unique case (phase_reg)
            PH_L1:   begin u_last = 2'd2; v_last = 2'd2; end
            PH_L2:   begin u_last = 2'd1; v_last = 2'd2; end
            PH_S:    begin u_last = 2'd2; v_last = 2'd1; end
            PH_NUM:  begin u_last = 2'd1; v_last = 2'd1; end
            PH_DEN:  begin u_last = 2'd3; v_last = 2'd3; end
            PH_LIM:  begin u_last = 2'd0; v_last = 2'd2; end
            default: begin u_last = 2'd0; v_last = 2'd0; end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        gap_next   = gap_reg;
        unique case (state_reg)
            E_IDLE:
            begin
                if (!head_empty)
                begin
                    state_next = E_RUN;
                    phase_next = PH_L1;
                    u_next     = '0;
                    v_next     = '0;
                end
            end
            E_RUN:
            begin
                if (v_reg == v_last)
                begin
                    v_next = '0;
                    if (u_reg == u_last)
                    begin
                        u_next     = '0;
                        gap_next   = '0;
                        state_next = E_GAP;
                    end
                    else
                    begin
                        u_next = u_reg + 1'b1;
                    end
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            E_GAP:
            begin
                // lets the last step of a phase reach its result register
                if (gap_reg == GAP_LAST)
                begin
                    if (phase_reg == PH_LIM)
                    begin
                        state_next = E_DECIDE;
                    end
                    else
                    begin
                        phase_next = phase_after(phase_reg);
                        state_next = E_RUN;
                    end
                end
                else
                begin
                    gap_next = gap_reg + 1'b1;
                end
            end
            E_DECIDE:
            begin
                if (res_ready)
                begin
                    state_next = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        head_pop   = 1'b0;
        issue      = 1'b0;
        res_valid  = 1'b0;
        decide_now = 1'b0;
        unique case (state_reg)
            E_IDLE:   head_pop   = !head_empty;
            E_RUN:    issue      = 1'b1;
            E_GAP:    decide_now = (gap_reg == GAP_LAST) && (phase_reg == PH_LIM);
            E_DECIDE: res_valid  = 1'b1;
            default:  issue      = 1'b0;
        endcase
    end

    assign verdict.is_inlier = inl_reg;
    assign verdict.last      = item_reg.last;

    // matrix coefficient, transposed for the second line
    assign rows     = {f_row_three, f_row_two, f_row_one};
    assign coef_r   = (phase_reg == PH_L2) ? v_reg : u_reg;
    assign coef_c   = (phase_reg == PH_L2) ? u_reg : v_reg;
    assign coef     = rows[coef_r][COEF_W*coef_c +: COEF_W];
    assign coef_neg = coef[COEF_W-1];
    assign coef_mag = coef_neg ? COEF_W'(-coef) : coef;
    assign den_line = u_reg[1] ? l2_mag_reg[u_reg[0]] : l1_mag_reg[{1'b0, u_reg[0]}];

    always_comb
    begin
        a_sel         = '0;
        b_sel         = '0;
        ctl_sel.valid = issue;
        ctl_sel.neg   = 1'b0;
        ctl_sel.shift = '0;
        ctl_sel.phase = phase_reg;
        ctl_sel.idx   = u_reg;
        ctl_sel.first = (u_reg == '0) && (v_reg == '0);
        ctl_sel.last  = (u_reg == u_last) && (v_reg == v_last);
        unique case (phase_reg)
            PH_L1:
            begin
                // one line component per outer step
                a_sel         = MUL_W'(coef_mag);
                b_sel         = MUL_W'(item_reg.p1_mag[v_reg]);
                ctl_sel.neg   = coef_neg ^ item_reg.p1_neg[v_reg];
                ctl_sel.first = (v_reg == '0);
                ctl_sel.last  = (v_reg == v_last);
            end
            PH_L2:
            begin
                a_sel         = MUL_W'(coef_mag);
                b_sel         = MUL_W'(item_reg.p2_mag[v_reg]);
                ctl_sel.neg   = coef_neg ^ item_reg.p2_neg[v_reg];
                ctl_sel.first = (v_reg == '0);
                ctl_sel.last  = (v_reg == v_last);
            end
            PH_S:
            begin
                a_sel         = l_chunk(l1_mag_reg[u_reg], v_reg[0]);
                b_sel         = MUL_W'(item_reg.p2_mag[u_reg]);
                ctl_sel.neg   = l1_neg_reg[u_reg] ^ item_reg.p2_neg[u_reg];
                ctl_sel.shift = v_reg;
            end
            PH_NUM:
            begin
                a_sel         = s_chunk(s_mag_reg, u_reg[0]);
                b_sel         = s_chunk(s_mag_reg, v_reg[0]);
                ctl_sel.shift = {1'b0, u_reg[0]} + {1'b0, v_reg[0]};
            end
            PH_DEN:
            begin
                a_sel         = l_chunk(den_line, v_reg[1]);
                b_sel         = l_chunk(den_line, v_reg[0]);
                ctl_sel.shift = {1'b0, v_reg[1]} + {1'b0, v_reg[0]};
            end
            PH_LIM:
            begin
                a_sel         = inlier_limit;
                b_sel         = d_chunk(den_reg, v_reg);
                ctl_sel.shift = v_reg;
            end
            default:
            begin
                a_sel = '0;
            end
        endcase
    end

    // accumulate stage
    always_comb
    begin
        unique case (ctl2_reg.shift)
            2'd0:    addend = ACC_W'(prod_reg);
            2'd1:    addend = ACC_W'(prod_reg) << MUL_W;
            default: addend = ACC_W'(prod_reg) << (2 * MUL_W);
        endcase
        base     = ctl2_reg.first ? '0 : acc_reg;
        acc_next = ctl2_reg.neg ? base - addend : base + addend;
    end

    assign acc_abs    = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign num_scaled = {num_reg, {THR_FRAC{1'b0}}};
    assign lim_ext    = CMP_W'(acc_reg[LIM_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            phase_reg <= PH_L1;
            u_reg     <= '0;
            v_reg     <= '0;
            gap_reg   <= '0;
            ctl1_reg  <= '0;
            ctl2_reg  <= '0;
            ctl3_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            gap_reg   <= gap_next;
            ctl1_reg  <= ctl_sel;
            ctl2_reg  <= ctl1_reg;
            ctl3_reg  <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            item_reg <= head;
        end
        a_reg    <= a_sel;
        b_reg    <= b_sel;
        prod_reg <= a_reg * b_reg;
        if (ctl2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (ctl3_reg.valid && ctl3_reg.last)
        begin
            unique case (ctl3_reg.phase)
                PH_L1:
                begin
                    l1_mag_reg[ctl3_reg.idx] <= acc_abs[L_MAG_W-1:0];
                    l1_neg_reg[ctl3_reg.idx] <= acc_reg[ACC_W-1];
                end
                PH_L2:   l2_mag_reg[ctl3_reg.idx[0]] <= acc_abs[L_MAG_W-1:0];
                PH_S:    s_mag_reg <= acc_abs[S_MAG_W-1:0];
                PH_NUM:  num_reg   <= acc_reg[NUM_W-1:0];
                PH_DEN:  den_reg   <= acc_reg[DEN_W-1:0];
                default: ;
            endcase
        end
        if (decide_now)
        begin
            // zero denominator never counts
            inl_reg <= (den_reg != '0) && (num_scaled < lim_ext);
        end
    end

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> !head_empty)
        else $error("pop from empty request queue");

    a_loop_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_RUN) |-> ((u_reg <= u_last) && (v_reg <= v_last)))
        else $error("step counters outside phase bounds");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == E_DECIDE) |-> (!ctl1_reg.valid && !ctl2_reg.valid && !ctl3_reg.valid))
        else $error("verdict issued before multiply pipeline drained");
`endif

endmodule

### rtl/sampson_inlier_counter.sv
// ----------------------------------------------------------------------------
// sampson_inlier_counter
// sampson distance inlier test of point pairs against a loaded fundamental
// matrix, with a running per-set inlier count
// ----------------------------------------------------------------------------
// a request waits in the front queue until the back end takes it, and its result
// is registered in the output slot; the back end takes no new request until then:
//   it runs 44 multiply steps plus phase gaps on one shared 32x32 multiplier
// up to 4 requests queue in front while the back end works or a result waits
// reset: rst_n clears the queue, sequencer, output and inlier count at once;
//   matrix rows reset to zero and the threshold to 1.0
module sampson_inlier_counter import sic_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request side
    input  logic                 push,
    output logic                 full,
    input  pair_t                item,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data
);

    // configuration registers
    logic [ROW_W-1:0]   f_row_one_reg;
    logic [ROW_W-1:0]   f_row_two_reg;
    logic [ROW_W-1:0]   f_row_three_reg;
    logic [LIMIT_W-1:0] inlier_limit_reg;
    logic               cfg_fire;

    // front to back
    entry_t   head;
    logic     head_empty;
    logic     head_pop;

    // back to output stage
    verdict_t verdict;
    logic     res_valid;
    logic     res_ready;
    logic     res_fire;

    // running count and output register
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] total;
    logic             count_inc;
    result_t          out_reg;
    logic             out_valid_reg, out_valid_next;

    // config is always writable; writes only come while the block is idle (the user's rule, not enforced here)
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_row_one_reg    <= '0;
            f_row_two_reg    <= '0;
            f_row_three_reg  <= '0;
            inlier_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_F_ROW_ONE:    f_row_one_reg    <= cfg_data;
                REG_F_ROW_TWO:    f_row_two_reg    <= cfg_data;
                REG_F_ROW_THREE:  f_row_three_reg  <= cfg_data;
                REG_INLIER_LIMIT: inlier_limit_reg <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    // front end: request capture and sign / magnitude split
    sic_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop)
    );

    // back end: lines, algebraic error, squares, threshold product and inlier decision
    sic_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_empty   (head_empty),
        .head_pop     (head_pop),
        .f_row_one    (f_row_one_reg),
        .f_row_two    (f_row_two_reg),
        .f_row_three  (f_row_three_reg),
        .inlier_limit (inlier_limit_reg),
        .verdict      (verdict),
        .res_valid    (res_valid),
        .res_ready    (res_ready)
    );

    // output slot frees when empty or being popped this cycle
    assign res_ready = !out_valid_reg || pop;
    assign res_fire  = res_valid && res_ready;

    // saturating count, cleared after the last pair of a set
    assign count_inc = verdict.is_inlier && (count_reg < CNT_W'(MAX_PAIRS));
    assign total     = count_reg + CNT_W'(count_inc);

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (res_fire)
        begin
            count_next     = verdict.last ? '0 : total;
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            out_reg.is_inlier    <= verdict.is_inlier;
            out_reg.inlier_total <= total;
            out_reg.set_done     <= verdict.last;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

`ifndef SYNTH
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PAIRS))
        else $error("inlier count above saturation limit");

    a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && verdict.last) |=> (count_reg == '0))
        else $error("inlier count not cleared after last pair");
`endif

endmodule

### bench/sampson_inlier_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampson_inlier_counter_tb
// self-checking bench for the sampson inlier counter: a short table of
// hand-picked pairs and matrix loads, one long set of exact matches that
// keeps the running count climbing, then random phases of near-epipolar and
// raw pairs under randomly chosen matrices and thresholds; every result is
// compared with its typed row or an exact wide-integer scorer kept in the bench
// ----------------------------------------------------------------------------
module sampson_inlier_counter_tb;
    import sic_pkg::*;

    localparam int COEF_MAX    = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_MIN    = -(1 << (COEF_W - 1));
    localparam int HALF_PERIOD = 6;
    localparam int DRAIN_CYC   = 128;
    localparam int HOLD_CYC    = 700;   // long receiver hold-off
    localparam int LONG_PAIRS  = 200;
    localparam int RAND_PAIRS  = 1060;

    // one row of the directed table: either a register write or a request
    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [ROW_W-1:0]     data;
        pair_t                pr;
        logic                 typed;   // expectation written out in the row
        result_t              want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 push;
    logic                 full;
    pair_t                item;
    logic                 empty;
    logic                 pop;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;

    // scorer state: its own copy of the matrix, threshold and running count
    logic [ROW_W-1:0]     mtx_row [3] = '{default: '0};
    logic [LIMIT_W-1:0]   thr = LIMIT_RESET;
    int                   run_count = 0;

    logic [CFG_IDX_W-1:0] row_reg [3] = '{REG_F_ROW_ONE, REG_F_ROW_TWO, REG_F_ROW_THREE};

    result_t              pending_results [$];
    result_t              oldest;
    stim_row_t            directed [$];
    int                   err_count    = 0;
    int                   results_seen = 0;
    int                   pairs_sent   = 0;

    sampson_inlier_counter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------
    // scorer
    // ------------------------------------------------------------------

    function automatic logic [127:0] square_mag(longint v);
        logic [127:0] m;
        m = (v < 0) ? 128'(-v) : 128'(v);
        return m * m;
    endfunction

    // exact sampson test, no division: s^2 * 2^16 < threshold * den
    function automatic result_t score_pair(pair_t pr);
        longint       fc [3][3];
        longint       a [3];
        longint       b [3];
        longint       l1 [3];
        longint       l2 [2];
        longint       s;
        logic [127:0] num_sc;
        logic [127:0] den;
        logic [127:0] lim;
        logic         hit;
        result_t      r;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                fc[i][j] = longint'($signed(mtx_row[i][j*COEF_W +: COEF_W]));
            end
        end
        a[0] = longint'(pr.first_x);
        a[1] = longint'(pr.first_y);
        a[2] = longint'(pr.first_w);
        b[0] = longint'(pr.second_x);
        b[1] = longint'(pr.second_y);
        b[2] = longint'(pr.second_w);
        // epipolar line in the second image, F * p1
        for (int i = 0; i < 3; i++)
        begin
            l1[i] = fc[i][0] * a[0] + fc[i][1] * a[1] + fc[i][2] * a[2];
        end
        // x and y of the line in the first image, F^T * p2
        for (int j = 0; j < 2; j++)
        begin
            l2[j] = fc[0][j] * b[0] + fc[1][j] * b[1] + fc[2][j] * b[2];
        end
        s      = b[0] * l1[0] + b[1] * l1[1] + b[2] * l1[2];
        num_sc = square_mag(s) << THR_FRAC;
        den    = square_mag(l1[0]) + square_mag(l1[1])
               + square_mag(l2[0]) + square_mag(l2[1]);
        lim    = {96'b0, thr} * den;
        // a zero denominator never counts
        hit    = (den != '0) && (num_sc < lim);
        if (hit && run_count < MAX_PAIRS)
        begin
            run_count++;
        end
        r.is_inlier    = hit;
        r.inlier_total = CNT_W'(run_count);
        r.set_done     = pr.last_pair;
        if (pr.last_pair)
        begin
            run_count = 0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [ROW_W-1:0] pack_row(int c0, int c1, int c2);
        return {c2[COEF_W-1:0], c1[COEF_W-1:0], c0[COEF_W-1:0]};
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        stim_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic stim_row_t pair_row(int x1, int y1, int w1, int x2, int y2, int w2,
                                           bit last, bit typed = 0, bit inl = 0, int tot = 0);
        stim_row_t row;
        row                   = '{default: '0};
        row.pr.first_x        = x1[PT_W-1:0];
        row.pr.first_y        = y1[PT_W-1:0];
        row.pr.first_w        = w1[PT_W-1:0];
        row.pr.second_x       = x2[PT_W-1:0];
        row.pr.second_y       = y2[PT_W-1:0];
        row.pr.second_w       = w2[PT_W-1:0];
        row.pr.last_pair      = last;
        row.typed             = typed;
        row.want.is_inlier    = inl;
        row.want.inlier_total = CNT_W'(tot);
        row.want.set_done     = last;
        return row;
    endfunction

    // mostly a pair close to the epipolar geometry of a skew matrix,
    // sometimes raw bits in every field
    function automatic pair_t random_pair();
        pair_t pr;
        int    span;
        int    x;
        int    y;
        int    w;
        int    dx;
        int    dy;
        if ($urandom_range(0, 99) < 15)
        begin
            pr = pair_t'({$urandom, $urandom, $urandom, 1'b0});
        end
        else
        begin
            span = ($urandom_range(0, 3) == 0) ? 32000 : 2000;
            x    = int'($urandom_range(0, 2 * span)) - span;
            y    = int'($urandom_range(0, 2 * span)) - span;
            w    = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 64)) - 32 : 1;
            dx   = x + int'($urandom_range(0, 6)) - 3;
            dy   = y + int'($urandom_range(0, 6)) - 3;
            pr.first_x  = x[PT_W-1:0];
            pr.first_y  = y[PT_W-1:0];
            pr.first_w  = w[PT_W-1:0];
            pr.second_x = dx[PT_W-1:0];
            pr.second_y = dy[PT_W-1:0];
            pr.second_w = w[PT_W-1:0];
        end
        pr.last_pair = ($urandom_range(0, 15) == 0);
        return pr;
    endfunction

    task automatic note_error(string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // offer one request until the block takes it; push drops now and then
    // while waiting, except inside the calm window
    task automatic send_pair(pair_t pr, bit typed = 0, result_t want = '0);
        result_t pred;
        bit      calm;
        calm = (pairs_sent >= 1000 && pairs_sent < 1400);
        forever
        begin
            @(negedge clk);
            item = pr;
            push = calm || ($urandom_range(0, 99) >= 6);
            @(posedge clk);
            if (push && !full)
            begin
                break;
            end
        end
        // the scorer runs for every request so the count stays in step
        pred = score_pair(pr);
        pending_results.insert(pending_results.size(), typed ? want : pred);
        pairs_sent++;
        // an occasional long gap lets the block drain so gaps land on
        // every phase of its work
        if (!calm && $urandom_range(0, 99) < 3)
        begin
            @(negedge clk);
            push = 1'b0;
            repeat ($urandom_range(1, 150)) @(negedge clk);
        end
    endtask

    // block is idle once every expected result has been taken
    task automatic settle();
        @(negedge clk);
        push = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            REG_F_ROW_ONE:    mtx_row[0] = data;
            REG_F_ROW_TWO:    mtx_row[1] = data;
            REG_F_ROW_THREE:  mtx_row[2] = data;
            REG_INLIER_LIMIT: thr        = data[LIMIT_W-1:0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // k * [t]x: p2 = p1 gives a zero algebraic error
    task automatic load_skew(int tx, int ty, int tz, int k);
        write_reg(REG_F_ROW_ONE,   pack_row(0, -tz * k, ty * k));
        write_reg(REG_F_ROW_TWO,   pack_row(tz * k, 0, -tx * k));
        write_reg(REG_F_ROW_THREE, pack_row(-ty * k, tx * k, 0));
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver: random pops, one long hold-off so the request queue fills
    // and full stalls the sender, and a calm window with no idling
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        pop  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 150)
            begin
                held = 1'b1;
                pop  = 1'b0;
                repeat (HOLD_CYC) @(negedge clk);
            end
            pop = (results_seen >= 1000 && results_seen < 1400)
                || ($urandom_range(0, 99) >= 6);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                note_error($sformatf("result %0d with nothing pending", results_seen));
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (result.is_inlier !== oldest.is_inlier)
                begin
                    note_error($sformatf("result %0d is_inlier got %b want %b",
                        results_seen, result.is_inlier, oldest.is_inlier));
                end
                if (result.inlier_total !== oldest.inlier_total)
                begin
                    note_error($sformatf("result %0d inlier_total got %0d want %0d",
                        results_seen, result.inlier_total, oldest.inlier_total));
                end
                if (result.set_done !== oldest.set_done)
                begin
                    note_error($sformatf("result %0d set_done got %b want %b",
                        results_seen, result.set_done, oldest.set_done));
                end
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        pair_t sp;
        int    x;
        int    y;
        int    n;
        int    c [3];
        int    random_sent;

        push      = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_F_ROW_ONE;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed = '{
            // all-zero matrix after reset: nothing counts, even at the extremes
            pair_row(32767, 32767, 32767, 32767, 32767, 32767, 0, 1, 0, 0),
            pair_row(-32768, -32768, -32768, -32768, -32768, -32768, 1, 1, 0, 0),
            // rotation about the optical axis, threshold still 1.0
            cfg_row(REG_F_ROW_ONE,   pack_row(0, -1, 0)),
            cfg_row(REG_F_ROW_TWO,   pack_row(1, 0, 0)),
            cfg_row(REG_F_ROW_THREE, pack_row(0, 0, 0)),
            pair_row(10, 20, 1, 10, 20, 1, 0, 1, 1, 1),
            // both lines vanish at the origin: zero denominator
            pair_row(0, 0, 1, 0, 0, 1, 0, 1, 0, 1),
            pair_row(10, 20, 1, 10, 25, 1, 0),
            // zero threshold rejects even an exact match; end of set
            cfg_row(REG_INLIER_LIMIT, '0),
            pair_row(10, 20, 1, 10, 20, 1, 1, 1, 0, 1),
            // largest threshold, upper data bits set as well
            cfg_row(REG_INLIER_LIMIT, '1),
            pair_row(10, 20, 1, 10, 25, 1, 0),
            // extreme coefficients with extreme points
            cfg_row(REG_F_ROW_ONE,   pack_row(COEF_MAX, COEF_MAX, COEF_MAX)),
            cfg_row(REG_F_ROW_TWO,   pack_row(COEF_MIN, COEF_MIN, COEF_MIN)),
            cfg_row(REG_F_ROW_THREE, pack_row(COEF_MAX, COEF_MIN, COEF_MAX)),
            pair_row(32767, -32768, 32767, -32768, 32767, -32768, 0),
            pair_row(-32768, -32768, -32768, -32768, -32768, -32768, 0),
            pair_row(32767, 32767, 32767, 32767, 32767, 32767, 1),
            // only the weight term: large numerator over a zero denominator
            cfg_row(REG_F_ROW_ONE,   '0),
            cfg_row(REG_F_ROW_TWO,   '0),
            cfg_row(REG_F_ROW_THREE, pack_row(0, 0, 1)),
            pair_row(5, 7, -32768, 3, 9, -32768, 1, 1, 0, 0)
        };

        foreach (directed[k])
        begin
            if (directed[k].is_cfg)
            begin
                settle();
                write_reg(directed[k].idx, directed[k].data);
            end
            else
            begin
                send_pair(directed[k].pr, directed[k].typed, directed[k].want);
            end
        end

        // one long set of exact matches keeps the count climbing;
        // the weight does not enter the lines of this matrix
        settle();
        load_skew(0, 0, 1, 1);
        write_reg(REG_INLIER_LIMIT, ROW_W'(LIMIT_RESET));
        for (int k = 0; k < LONG_PAIRS; k++)
        begin
            x = int'($urandom_range(1, 30000));
            y = int'($urandom_range(0, 60000)) - 30000;
            sp.first_x   = x[PT_W-1:0];
            sp.first_y   = y[PT_W-1:0];
            sp.first_w   = PT_W'($urandom);
            sp.second_x  = sp.first_x;
            sp.second_y  = sp.first_y;
            sp.second_w  = sp.first_w;
            sp.last_pair = (k == LONG_PAIRS - 1);
            send_pair(sp);
        end

        // random phases, each under a fresh matrix and threshold
        random_sent = 0;
        while (random_sent < RAND_PAIRS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    load_skew(int'($urandom_range(0, 2000)) - 1000,
                              int'($urandom_range(0, 2000)) - 1000,
                              int'($urandom_range(0, 2000)) - 1000,
                              int'($urandom_range(1, 1000)));
                end
                6, 7:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        write_reg(row_reg[r], ROW_W'({$urandom, $urandom}));
                    end
                end
                default:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            case ($urandom_range(0, 4))
                                0:       c[j] = COEF_MAX;
                                1:       c[j] = COEF_MIN;
                                2:       c[j] = 0;
                                3:       c[j] = 1;
                                default: c[j] = -1;
                            endcase
                        end
                        write_reg(row_reg[r], pack_row(c[0], c[1], c[2]));
                    end
                end
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(REG_INLIER_LIMIT, '0);
                1:       write_reg(REG_INLIER_LIMIT, '1);
                2:       write_reg(REG_INLIER_LIMIT, ROW_W'({$urandom, $urandom}));
                default: write_reg(REG_INLIER_LIMIT,
                             {31'($urandom), 32'($urandom_range(0, 32'h0010_0000))});
            endcase
            n = int'($urandom_range(20, 120));
            repeat (n)
            begin
                send_pair(random_pair());
                random_sent++;
            end
        end

        // drain, then watch a while longer for stray results
        settle();
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hard stop, several times the slowest legal run
    initial
    begin : watchdog
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
rtl/sic_pkg.sv
rtl/sic_front.sv
rtl/sic_engine.sv
rtl/sampson_inlier_counter.sv
bench/sampson_inlier_counter_tb.sv
